// ===== rtl/box_filter_3x3_u8_defines.svh =====
// Assertion macros for the box filter.
`ifndef BOX_FILTER_3X3_U8_DEFINES_SVH
`define BOX_FILTER_3X3_U8_DEFINES_SVH

`ifndef SYNTH
`define BF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BF_ASSERT_NOW(lbl, ante, cons, msg)
`define BF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/bf3_pkg.sv =====
`timescale 1ns / 1ps
package bf3_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int RST_WIDTH     = 640;
  localparam int RST_HEIGHT    = 480;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 16;
  localparam int FW_BITS   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // result queue, one entry per request that yields at least one result
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // floor(x / 9) = (x * 7282) >> 16 for x <= 9 * 255
  localparam logic [12:0] DIV9_MUL   = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  // result kinds, in emission order
  localparam int RES_LEFT   = 0;
  localparam int RES_MAIN   = 1;
  localparam int RES_RIGHT  = 2;
  localparam int RES_BOTTOM = 3;
  localparam int RES_N      = 4;

  typedef struct packed {
    logic [RES_N-1:0] mask;
    logic [15:0]      row;
    logic [11:0]      col;
    logic [11:0]      mcol;
    logic [7:0]       mid;
    logic [7:0]       mval;
    logic [7:0]       rval;
  } ent_t;

endpackage

// ===== rtl/box_filter_3x3_u8.sv =====
// Path: an accepted request passes stage 1 and stage 2 into the result queue, whose head is offered.
// Throughput: one pixel per cycle while each pixel yields at most one result and the output
//   is not stalled; results leave one per cycle, so bottom-row pixels and row ends slow input.
// Line stores are two single-port-read memories, read on accept, written back from stage 1.
// Reset: counters cleared, width 640 (clamped), height 480; line stores are not cleared.
`timescale 1ns / 1ps
`include "box_filter_3x3_u8_defines.svh"
module box_filter_3x3_u8 #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bf3_pkg::CFG_DW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   in_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_pixel_o,
  output logic [15:0]                  out_row_o,
  output logic [11:0]                  out_col_o,
  output logic                         run_last_o
);
  import bf3_pkg::*;

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RstWidth = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

  // configuration
  logic [CW-1:0] wlast_q;
  logic [15:0]   hlast_q;
  logic [31:0]   fw32;
  logic [31:0]   effw;
  logic [CW-1:0] wlast_cfg;
  logic [15:0]   hlast_cfg;

  always_comb begin
    fw32 = 32'(cfg_wdata_i[FW_BITS-1:0]);
    if (fw32 < 32'd3) begin
      effw = 32'd3;
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      effw = 32'(MAX_WIDTH);
    end else begin
      effw = fw32;
    end
    wlast_cfg = CW'(effw - 32'd1);
    hlast_cfg = (cfg_wdata_i < 16'd3) ? 16'd2 : cfg_wdata_i - 16'd1;
  end

  // handshake
  logic in_acc;
  logic out_acc;
  logic push;
  logic [2:0] occ;
  logic [2:0] cnt_q;
  logic s1_v_q;
  logic s2_v_q;

  assign occ        = cnt_q + 3'(s1_v_q) + 3'(s2_v_q);
  assign in_stall_o = (occ >= 3'(QDEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  // position counters
  logic [CW-1:0] col_q;
  logic [15:0]   row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= CW'(RstWidth - 1);
      hlast_q <= 16'(RST_HEIGHT - 1);
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          wlast_q <= wlast_cfg;
          col_q   <= '0;
          row_q   <= '0;
        end
        REG_FRAME_HEIGHT: begin
          hlast_q <= hlast_cfg;
          col_q   <= '0;
          row_q   <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      if (col_q == wlast_q) begin
        col_q <= '0;
        row_q <= (row_q >= hlast_q) ? 16'd0 : row_q + 16'd1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // line stores: read on accept, written back in stage 1
  logic [7:0] mem_above     [MAX_WIDTH];
  logic [7:0] mem_two_above [MAX_WIDTH];
  logic [7:0] mid_rd_q;
  logic [7:0] top_rd_q;

  logic [7:0]    s1_px_q;
  logic [CW-1:0] s1_col_q;
  logic [15:0]   s1_row_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem_above[s1_col_q] <= s1_px_q;
    end
    if (in_acc) begin
      mid_rd_q <= mem_above[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem_two_above[s1_col_q] <= mid_rd_q;
    end
    if (in_acc) begin
      top_rd_q <= mem_two_above[col_q];
    end
  end

  // stage 1: window, sum, result mask
  logic [7:0]       win_q [6];
  logic [11:0]      sum;
  logic [RES_N-1:0] mask;
  logic             r_ge2;

  always_comb begin
    sum = 12'(top_rd_q) + 12'(mid_rd_q) + 12'(s1_px_q);
    for (int k = 0; k < 6; k++) begin
      sum = sum + 12'(win_q[k]);
    end
    r_ge2            = (s1_row_q >= 16'd2);
    mask[RES_LEFT]   = r_ge2 && (s1_col_q == CW'(1));
    mask[RES_MAIN]   = (s1_row_q == 16'd1) || (r_ge2 && (s1_col_q >= CW'(2)));
    mask[RES_RIGHT]  = r_ge2 && (s1_col_q == wlast_q);
    mask[RES_BOTTOM] = r_ge2 && (s1_row_q == hlast_q);
  end

  logic [RES_N-1:0] s2_mask_q;
  logic             s2_copy_q;
  logic [11:0]      s2_sum_q;
  logic [7:0]       s2_px_q;
  logic [7:0]       s2_mid_q;
  logic [7:0]       s2_rval_q;
  logic [15:0]      s2_row_q;
  logic [11:0]      s2_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      s1_v_q <= in_acc;
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top_rd_q;
        win_q[4] <= mid_rd_q;
        win_q[5] <= s1_px_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q  <= in_pixel_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
    if (s1_v_q) begin
      s2_mask_q <= mask;
      s2_copy_q <= (s1_row_q == 16'd1);
      s2_sum_q  <= sum;
      s2_px_q   <= s1_px_q;
      s2_mid_q  <= mid_rd_q;
      s2_rval_q <= win_q[4];
      s2_row_q  <= s1_row_q;
      s2_col_q  <= 12'(s1_col_q);
    end
  end

  // stage 2: divide by nine (or copy the pixel on row 1), build queue entry
  logic [24:0] prod;
  ent_t        ent;

  always_comb begin
    prod      = 25'(s2_sum_q) * 25'(DIV9_MUL);
    ent.mask  = s2_mask_q;
    ent.row   = s2_row_q;
    ent.col   = s2_col_q;
    ent.mcol  = s2_copy_q ? s2_col_q : s2_col_q - 12'd1;
    ent.mid   = s2_mid_q;
    ent.mval  = s2_copy_q ? s2_px_q : prod[DIV9_SHIFT +: 8];
    ent.rval  = s2_rval_q;
  end

  assign push = s2_v_q && (s2_mask_q != '0);

  // result queue
  ent_t             q_mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q;
  logic [QAW-1:0]   rd_ptr_q;
  logic [RES_N-1:0] done_q;
  ent_t             head;
  logic [RES_N-1:0] rem;
  logic [RES_N-1:0] sel;
  logic             last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= ent;
    end
  end

  always_comb begin
    head = q_mem[rd_ptr_q];
    rem  = head.mask & ~done_q;
    sel  = rem & (~rem + RES_N'(1));
    last = ((rem & ~sel) == '0);
  end

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign run_last_o  = last;

  always_comb begin
    out_row_o = head.row - 16'd1;
    case (sel)
      RES_N'(1) << RES_LEFT: begin
        out_pixel_o = head.mid;
        out_col_o   = 12'd0;
      end
      RES_N'(1) << RES_MAIN: begin
        out_pixel_o = head.mval;
        out_col_o   = head.mcol;
      end
      RES_N'(1) << RES_RIGHT: begin
        out_pixel_o = head.rval;
        out_col_o   = head.col;
      end
      default: begin
        out_pixel_o = head.mid;
        out_col_o   = head.col;
        out_row_o   = head.row;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      done_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (out_acc) begin
        if (last) begin
          done_q   <= '0;
          rd_ptr_q <= rd_ptr_q + QAW'(1);
        end else begin
          done_q <= done_q | sel;
        end
      end
      cnt_q <= cnt_q + 3'(push) - 3'(out_acc && last);
    end
  end

  `BF_ASSERT_NOW(a_occ_bound, 1'b1, occ <= 3'(QDEPTH), "result queue overcommitted")
  `BF_ASSERT_NOW(a_head_live, out_valid_o, rem != '0, "queue head has no pending result")
  `BF_ASSERT_NEXT(a_s1_follow, in_acc, s1_v_q, "accepted request missing from stage 1")
  `BF_ASSERT_NEXT(a_s2_follow, s1_v_q, s2_v_q, "stage 1 request missing from stage 2")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bf3_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum {PAT_RANDOM, PAT_EXTREME, PAT_WHITE, PAT_BLACK} pixel_pattern_e;

  typedef struct {
    logic [7:0]  pix;
    logic [15:0] row;
    logic [11:0] col;
    logic        last;
  } blur_out_t;

  class box_blur_mirror;
    logic [7:0]  line_up  [MAX_WIDTH_DEF];
    logic [7:0]  line_up2 [MAX_WIDTH_DEF];
    logic [7:0]  win [6];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    blur_out_t   blurred_q [$];
    int          errors;

    function new();
      foreach (line_up[i]) begin
        line_up[i]  = '0;
        line_up2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = 13'(RST_WIDTH);
      height_reg = 16'(RST_HEIGHT);
      errors     = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function int pending();
      return blurred_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data[12:0];
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data;
        end
        default: begin
          return;
        end
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    function blur_out_t make_out(int unsigned pix, int unsigned row, int unsigned col);
      blur_out_t o;
      o.pix  = pix[7:0];
      o.row  = row[15:0];
      o.col  = col[11:0];
      o.last = 1'b0;
      return o;
    endfunction

    // request accepted: queue the pixels it produces
    function void take_pixel(logic [7:0] px);
      int unsigned w, h, c, r, ci, sum;
      logic [7:0]  top, mid;
      blur_out_t   res [4];
      int          n;
      w   = eff_width();
      h   = eff_height();
      c   = col_pos;
      r   = row_pos;
      ci  = c % MAX_WIDTH_DEF;
      top = line_up2[ci];
      mid = line_up[ci];
      n   = 0;
      if (r == 1) begin
        res[n] = make_out(px, 0, c);
        n++;
      end else if (r >= 2) begin
        if (c == 1) begin
          res[n] = make_out(mid, r - 1, 0);
          n++;
        end
        if (c >= 2) begin
          sum = top;
          sum += mid;
          sum += px;
          foreach (win[k]) sum += win[k];
          res[n] = make_out(sum / 9, r - 1, c - 1);
          n++;
        end
        if (c == w - 1) begin
          res[n] = make_out(win[4], r - 1, w - 1);
          n++;
        end
        if (r == h - 1) begin
          res[n] = make_out(mid, h - 1, c);
          n++;
        end
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) blurred_q.push_back(res[i]);

      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      line_up2[ci] = mid;
      line_up[ci]  = px;
      if (c >= w - 1) begin
        col_pos = 0;
        row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_output(logic [7:0] pix, logic [15:0] row, logic [11:0] col,
                               logic last);
      blur_out_t want;
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected output pixel=%0d row=%0d col=%0d last=%0b",
                 $time, pix, row, col, last);
        errors++;
        return;
      end
      want = blurred_q.pop_front();
      if (want.pix !== pix) begin
        $display("%0t: out_pixel expected %0d actual %0d (row %0d col %0d)",
                 $time, want.pix, pix, want.row, want.col);
        errors++;
      end
      if (want.row !== row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, want.row, row);
        errors++;
      end
      if (want.col !== col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, want.col, col);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: run_last expected %0b actual %0b (row %0d col %0d)",
                 $time, want.last, last, want.row, want.col);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DW-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           in_pixel_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           out_pixel_o;
  logic [15:0]          out_row_o;
  logic [11:0]          out_col_o;
  logic                 run_last_o;

  bit             idle_on = 1'b1;
  int             cycles  = 0;
  box_blur_mirror blur    = new();

  box_filter_3x3_u8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .run_last_o  (run_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        blur.check_output(out_pixel_o, out_row_o, out_col_o, run_last_o);
      end
      out_stall_i <= idle_on && ($urandom_range(99) < 22);
    end
  end

  function automatic logic [7:0] pick_pixel(pixel_pattern_e pat);
    case (pat)
      PAT_WHITE:   return 8'hFF;
      PAT_BLACK:   return 8'h00;
      PAT_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:     return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] px);
    if (idle_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    blur.take_pixel(px);
  endtask

  task automatic send_frame(input int count, input pixel_pattern_e pat);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel(pat));
  endtask

  task automatic wait_for_quiet(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (blur.pending() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    wait_for_quiet(8);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blur.set_reg(idx, val);
  endtask

  initial begin
    int             random_items;
    int             total, stop_at, nframes, dice, sel;
    logic [15:0]    wval, hval;
    bit             pressure_done;
    pixel_pattern_e pat;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // widths and heights below 3 clamp to a 3x3 frame
    program_reg(REG_FRAME_WIDTH, 16'd0);
    program_reg(REG_FRAME_HEIGHT, 16'd1);
    send_frame(9, PAT_WHITE);
    send_frame(9, PAT_EXTREME);
    send_frame(4, PAT_RANDOM);
    program_reg(REG_FRAME_WIDTH, 16'd5);

    random_items  = 0;
    pressure_done = 1'b0;
    while (random_items < 200) begin
      wval = 16'($urandom_range(12, 3));
      dice = $urandom_range(99);
      if (dice < 12) wval = 16'($urandom_range(2, 0));
      else if (dice < 24) wval = wval | 16'($urandom_range(7, 1) << 13);
      hval = 16'($urandom_range(6, 3));
      if ($urandom_range(99) < 10) hval = 16'($urandom_range(2, 0));
      sel = $urandom_range(2);
      if (sel != 1) program_reg(REG_FRAME_WIDTH, wval);
      if (sel != 0) program_reg(REG_FRAME_HEIGHT, hval);

      nframes = $urandom_range(3, 1);
      for (int f = 0; f < nframes; f++) begin
        total   = blur.eff_width() * blur.eff_height();
        stop_at = total;
        if ($urandom_range(99) < 15) stop_at = $urandom_range(total - 1, 1);
        pat = ($urandom_range(9) < 2) ? PAT_EXTREME : PAT_RANDOM;
        idle_on = !(random_items >= 110 && random_items < 190);
        if (!pressure_done) begin
          send_frame(stop_at / 2, pat);
          wait_for_quiet(2);
          send_frame(stop_at - stop_at / 2, pat);
          pressure_done = 1'b1;
        end else begin
          send_frame(stop_at, pat);
        end
        random_items += stop_at;
        if (stop_at < total) break;
      end
    end
    idle_on = 1'b1;

    // tall frame never reaches its bottom row
    program_reg(REG_FRAME_WIDTH, 16'd3);
    program_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    send_frame(12, PAT_RANDOM);
    program_reg(REG_FRAME_WIDTH, 16'd4096);
    send_frame(5, PAT_RANDOM);
    // width register saturated at the widest line
    program_reg(REG_FRAME_HEIGHT, 16'd3);
    program_reg(REG_FRAME_WIDTH, 16'hFFFF);
    send_frame(6, PAT_RANDOM);

    wait_for_quiet(12);
    if (blur.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
